// File: src/tcrw_pkg.sv
// Shared types and constants for the text cell run writer.
// Field widths, command and status codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package tcrw_pkg;

	localparam int CMD_W    = 2;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int MARK_W   = 7;

	// Sum widths of origin + cursor and of start + count
	localparam int ROW_SUM_W = ROW_W + 1;
	localparam int END_SUM_W = COL_W + 2;

	localparam int CELL_W = 2 * BYTE_W;

	localparam logic [CMD_W-1:0] CMD_ATTR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CHAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BOTH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLIP   = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MARK,
		S_RUN,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;       // capture the input transaction
		logic mark_rd;    // read the row's dirty marks, set up the run
		logic cell_step;  // issue one cell read when cells remain
		logic finish;     // update marks and load the result register
	} ctrl_cmd_t;

	typedef struct packed {
		logic run_done;   // no cells left to issue
		logic out_busy;   // result register holds a result not taken
	} ctrl_sts_t;

endpackage

`default_nettype wire

// File: src/tcrw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcrw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: src/tcrw_ctrl.sv
// Controller state machine for the text cell run writer.
// Depends on tcrw_pkg for the state type and command/status structs.
`default_nettype none

module tcrw_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire tcrw_pkg::ctrl_sts_t sts,
	output tcrw_pkg::ctrl_cmd_t     cmd
);

	tcrw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcrw_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tcrw_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tcrw_pkg::S_MARK;
				end
			end
			tcrw_pkg::S_MARK: begin
				cmd.mark_rd = 1'b1;
				state_d     = tcrw_pkg::S_RUN;
			end
			tcrw_pkg::S_RUN: begin
				cmd.cell_step = 1'b1;
				if (sts.run_done) begin
					state_d = tcrw_pkg::S_FIN;
				end
			end
			tcrw_pkg::S_FIN: begin
				// hold until the previous result has been taken
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = tcrw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tcrw_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: src/tcrw_dp.sv
// Datapath of the text cell run writer: input capture, screen cell memory
// with read-modify-write pipe, dirty-mark memory and result register.
// Depends on tcrw_pkg and tcrw_ram.
`default_nettype none

module tcrw_dp #(
	parameter int SCREEN_ROWS = 25,
	parameter int SCREEN_COLS = 80
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tcrw_pkg::ctrl_cmd_t              cmd,
	output tcrw_pkg::ctrl_sts_t                   sts,
	input  wire logic [tcrw_pkg::CMD_W-1:0]       command,
	input  wire logic [tcrw_pkg::ROW_W-1:0]       origin_row,
	input  wire logic [tcrw_pkg::ROW_W-1:0]       cursor_row,
	input  wire logic [tcrw_pkg::COL_W-1:0]       origin_col,
	input  wire logic [tcrw_pkg::COL_W-1:0]       cursor_col,
	input  wire logic [tcrw_pkg::BYTE_W-1:0]      char_code,
	input  wire logic [tcrw_pkg::BYTE_W-1:0]      attr_byte,
	input  wire logic [tcrw_pkg::COUNT_W-1:0]     run_count,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [tcrw_pkg::STATUS_W-1:0]    status,
	output logic      [tcrw_pkg::MARK_W-1:0]      left_dirty_out,
	output logic      [tcrw_pkg::MARK_W-1:0]      right_dirty_out,
	output logic                                  delta_out
);

	localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
	localparam int RW    = $clog2(SCREEN_ROWS > 1 ? SCREEN_ROWS : 2);
	localparam int AW    = $clog2(CELLS > 1 ? CELLS : 2);
	localparam int CW    = $clog2(SCREEN_COLS + 1);
	localparam int BW    = tcrw_pkg::BYTE_W;

	localparam logic [tcrw_pkg::ROW_SUM_W:0]   ROWS_E = (tcrw_pkg::ROW_SUM_W + 1)'(SCREEN_ROWS);
	localparam logic [tcrw_pkg::END_SUM_W-1:0] COLS_E = tcrw_pkg::END_SUM_W'(SCREEN_COLS);
	localparam logic [CW-1:0]                  COLS_C = CW'(SCREEN_COLS);

	// Input capture
	logic [tcrw_pkg::ROW_SUM_W-1:0] row_sum;
	logic [tcrw_pkg::END_SUM_W-1:0] start_sum, end_sum, start_clip, end_clip;
	logic                           reject_d, clip_d;

	logic [tcrw_pkg::CMD_W-1:0] cmd_q;
	logic [RW-1:0]              row_q;
	logic                       reject_q, clip_q;
	logic [CW-1:0]              start_q, end_q;
	logic [BW-1:0]              char_q, attr_q;

	always_comb begin
		row_sum   = tcrw_pkg::ROW_SUM_W'(origin_row) + tcrw_pkg::ROW_SUM_W'(cursor_row);
		start_sum = tcrw_pkg::END_SUM_W'(origin_col) + tcrw_pkg::END_SUM_W'(cursor_col);
		end_sum   = start_sum + tcrw_pkg::END_SUM_W'(run_count);
		reject_d  = {1'b0, row_sum} >= ROWS_E;
		clip_d    = end_sum > COLS_E;
		end_clip  = clip_d ? COLS_E : end_sum;
		start_clip = (start_sum > COLS_E) ? COLS_E : start_sum;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= command;
			row_q    <= reject_d ? '0 : RW'(row_sum);
			reject_q <= reject_d;
			clip_q   <= clip_d;
			start_q  <= CW'(start_clip);
			end_q    <= CW'(end_clip);
			char_q   <= char_code;
			attr_q   <= attr_byte;
		end
	end

	// Cell run: issue reads, write the merged cell in the following cycle
	logic [AW-1:0] addr_q, waddr_s1;
	logic [CW-1:0] cnt_q;
	logic          issue, pend_s1;
	logic [tcrw_pkg::CELL_W-1:0] cell_rd, cell_wr;

	assign issue        = cmd.cell_step && (cnt_q != '0);
	assign sts.run_done = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.mark_rd) begin
			addr_q <= AW'(AW'(row_q) * AW'(SCREEN_COLS)) + AW'(start_q);
			cnt_q  <= reject_q ? '0 : (end_q - start_q);
		end else if (issue) begin
			addr_q <= addr_q + AW'(1);
			cnt_q  <= cnt_q - CW'(1);
		end
		waddr_s1 <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
		end
	end

	always_comb begin
		case (cmd_q)
			tcrw_pkg::CMD_ATTR: cell_wr = {attr_q, cell_rd[BW-1:0]};
			tcrw_pkg::CMD_CHAR: cell_wr = {cell_rd[2*BW-1:BW], char_q};
			default:            cell_wr = {attr_q, char_q};
		endcase
	end

	tcrw_ram #(
		.WIDTH(tcrw_pkg::CELL_W),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (pend_s1),
		.waddr(waddr_s1),
		.wdata(cell_wr),
		.re   (issue),
		.raddr(addr_q),
		.rdata(cell_rd)
	);

	// Dirty marks: memory plus a valid bit per row; an invalid row reads
	// as left = column count, right = 0.
	logic [SCREEN_ROWS-1:0] mark_vld_q;
	logic [2*CW-1:0]        mark_rd, mark_wr;
	logic                   row_vld;
	logic [CW-1:0]          left_old, right_old, left_new, right_new;
	logic                   mark_we;

	assign mark_we = cmd.finish && !reject_q;

	always_comb begin
		row_vld   = mark_vld_q[row_q];
		left_old  = row_vld ? mark_rd[2*CW-1:CW] : COLS_C;
		right_old = row_vld ? mark_rd[CW-1:0] : '0;
		left_new  = (start_q < left_old) ? start_q : left_old;
		right_new = (end_q > right_old) ? end_q : right_old;
		mark_wr   = {left_new, right_new};
	end

	tcrw_ram #(
		.WIDTH(2 * CW),
		.DEPTH(SCREEN_ROWS)
	) u_marks (
		.clk  (clk),
		.we   (mark_we),
		.waddr(row_q),
		.wdata(mark_wr),
		.re   (cmd.mark_rd),
		.raddr(row_q),
		.rdata(mark_rd)
	);

	// Valid bits, pending flag and result register
	logic delta_q, out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_vld_q  <= '0;
			delta_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (mark_we) begin
				mark_vld_q[row_q] <= 1'b1;
				delta_q           <= 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (reject_q) begin
				status          <= tcrw_pkg::ST_REJECT;
				left_dirty_out  <= '0;
				right_dirty_out <= '0;
				delta_out       <= delta_q;
			end else begin
				status          <= clip_q ? tcrw_pkg::ST_CLIP : tcrw_pkg::ST_OK;
				left_dirty_out  <= tcrw_pkg::MARK_W'(left_new);
				right_dirty_out <= tcrw_pkg::MARK_W'(right_new);
				delta_out       <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_busy = out_valid_q && !out_ready;

endmodule

`default_nettype wire

// File: src/text_cell_run_writer_unit.sv
// Top level of the text cell run writer: controller plus datapath.
// Depends on tcrw_pkg, tcrw_ctrl, tcrw_dp (which holds tcrw_ram).
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   input    | in_valid / in_ready  | command, origin/cursor row and col, bytes, run_count
//   result   | out_valid/ out_ready | status, left_dirty_out, right_dirty_out, delta_out
//
// The result is loaded once the run of N cells is done, N being the clipped
// run length (0 to SCREEN_COLS): the cell memory takes one read-modify-write
// per cycle. Input is taken again the cycle after the result is loaded, so
// a transaction is accepted only after the previous result has been loaded.
// A result waiting on out_ready does not block acceptance; only the next
// result's load waits for it. Reset clears control, dirty-mark valid bits
// and the pending flag; the cell memory is not cleared.
`default_nettype none

module text_cell_run_writer_unit #(
	parameter int SCREEN_ROWS = 25,
	parameter int SCREEN_COLS = 80
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [tcrw_pkg::CMD_W-1:0]       command,
	input  wire logic [tcrw_pkg::ROW_W-1:0]       origin_row,
	input  wire logic [tcrw_pkg::ROW_W-1:0]       cursor_row,
	input  wire logic [tcrw_pkg::COL_W-1:0]       origin_col,
	input  wire logic [tcrw_pkg::COL_W-1:0]       cursor_col,
	input  wire logic [tcrw_pkg::BYTE_W-1:0]      char_code,
	input  wire logic [tcrw_pkg::BYTE_W-1:0]      attr_byte,
	input  wire logic [tcrw_pkg::COUNT_W-1:0]     run_count,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [tcrw_pkg::STATUS_W-1:0]    status,
	output logic      [tcrw_pkg::MARK_W-1:0]      left_dirty_out,
	output logic      [tcrw_pkg::MARK_W-1:0]      right_dirty_out,
	output logic                                  delta_out
);

	tcrw_pkg::ctrl_cmd_t ctl_cmd;
	tcrw_pkg::ctrl_sts_t ctl_sts;

	tcrw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (ctl_sts),
		.cmd     (ctl_cmd)
	);

	tcrw_dp #(
		.SCREEN_ROWS(SCREEN_ROWS),
		.SCREEN_COLS(SCREEN_COLS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (ctl_cmd),
		.sts            (ctl_sts),
		.command        (command),
		.origin_row     (origin_row),
		.cursor_row     (cursor_row),
		.origin_col     (origin_col),
		.cursor_col     (cursor_col),
		.char_code      (char_code),
		.attr_byte      (attr_byte),
		.run_count      (run_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.left_dirty_out (left_dirty_out),
		.right_dirty_out(right_dirty_out),
		.delta_out      (delta_out)
	);

endmodule

`default_nettype wire

// File: tb/tb_text_cell_run_writer_unit.sv
// Self-checking testbench for text_cell_run_writer_unit: directed row, clip,
// command and empty-run cases, random runs under random stalls on both
// channels, then a stall-free stream. Depends on tcrw_pkg and the unit's RTL.
module tb_text_cell_run_writer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS         = 25;
	localparam int COLS         = 80;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [tcrw_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [tcrw_pkg::CMD_W-1:0]   command;
		logic [tcrw_pkg::ROW_W-1:0]   origin_row;
		logic [tcrw_pkg::ROW_W-1:0]   cursor_row;
		logic [tcrw_pkg::COL_W-1:0]   origin_col;
		logic [tcrw_pkg::COL_W-1:0]   cursor_col;
		logic [tcrw_pkg::BYTE_W-1:0]  char_code;
		logic [tcrw_pkg::BYTE_W-1:0]  attr_byte;
		logic [tcrw_pkg::COUNT_W-1:0] run_count;
	} run_req_t;

	typedef struct packed {
		logic [tcrw_pkg::STATUS_W-1:0] status;
		logic [tcrw_pkg::MARK_W-1:0]   left_mark;
		logic [tcrw_pkg::MARK_W-1:0]   right_mark;
		logic                          delta;
	} run_res_t;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [tcrw_pkg::CMD_W-1:0]    command;
	logic [tcrw_pkg::ROW_W-1:0]    origin_row;
	logic [tcrw_pkg::ROW_W-1:0]    cursor_row;
	logic [tcrw_pkg::COL_W-1:0]    origin_col;
	logic [tcrw_pkg::COL_W-1:0]    cursor_col;
	logic [tcrw_pkg::BYTE_W-1:0]   char_code;
	logic [tcrw_pkg::BYTE_W-1:0]   attr_byte;
	logic [tcrw_pkg::COUNT_W-1:0]  run_count;
	logic                          out_valid;
	logic                          out_ready;
	logic [tcrw_pkg::STATUS_W-1:0] status;
	logic [tcrw_pkg::MARK_W-1:0]   left_dirty_out;
	logic [tcrw_pkg::MARK_W-1:0]   right_dirty_out;
	logic                          delta_out;

	// Predicted screen state: dirty span per row, pending flag, cells written so far
	int       row_left[ROWS];
	int       row_right[ROWS];
	bit       screen_pending;
	bit       cell_written[ROWS*COLS];
	run_res_t expected_q[$];

	int fail_count;
	int checked;
	int rejects_seen;
	int clips_seen;
	bit calm;

	text_cell_run_writer_unit uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("tb_text_cell_run_writer_unit: errors");
		$finish;
	end

	function automatic run_res_t predict_run(run_req_t r);
		run_res_t res;
		int row;
		int first;
		int last;
		row = int'(r.origin_row) + int'(r.cursor_row);
		if (row >= ROWS) begin
			res.status     = tcrw_pkg::ST_REJECT;
			res.left_mark  = '0;
			res.right_mark = '0;
			res.delta      = screen_pending;
			return res;
		end
		first = int'(r.origin_col) + int'(r.cursor_col);
		last  = first + int'(r.run_count);
		res.status = tcrw_pkg::ST_OK;
		if (last > COLS) begin
			last = COLS;
			res.status = tcrw_pkg::ST_CLIP;
		end
		if (first > COLS)
			first = COLS;
		for (int c = first; c < last; c++)
			cell_written[row*COLS + c] = 1'b1;
		if (first < row_left[row])
			row_left[row] = first;
		if (last > row_right[row])
			row_right[row] = last;
		screen_pending = 1'b1;
		res.left_mark  = tcrw_pkg::MARK_W'(row_left[row]);
		res.right_mark = tcrw_pkg::MARK_W'(row_right[row]);
		res.delta      = 1'b1;
		return res;
	endfunction

	function automatic run_req_t make_req(logic [tcrw_pkg::CMD_W-1:0] cmd, int orow, int crow,
			int ocol, int ccol, int ch, int attr, int count);
		run_req_t r;
		r.command    = cmd;
		r.origin_row = tcrw_pkg::ROW_W'(orow);
		r.cursor_row = tcrw_pkg::ROW_W'(crow);
		r.origin_col = tcrw_pkg::COL_W'(ocol);
		r.cursor_col = tcrw_pkg::COL_W'(ccol);
		r.char_code  = tcrw_pkg::BYTE_W'(ch);
		r.attr_byte  = tcrw_pkg::BYTE_W'(attr);
		r.run_count  = tcrw_pkg::COUNT_W'(count);
		return r;
	endfunction

	function automatic run_req_t random_req();
		run_req_t r;
		int target;
		r.command = tcrw_pkg::CMD_W'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < 85) begin
			target = $urandom_range(0, ROWS-1);
			r.origin_row = tcrw_pkg::ROW_W'($urandom_range(0, target));
			r.cursor_row = tcrw_pkg::ROW_W'(target - int'(r.origin_row));
		end else begin
			r.origin_row = tcrw_pkg::ROW_W'($urandom);
			r.cursor_row = tcrw_pkg::ROW_W'($urandom);
		end
		if ($urandom_range(0, 99) < 70) begin
			target = $urandom_range(0, COLS-1);
			r.origin_col = tcrw_pkg::COL_W'($urandom_range(0, target));
			r.cursor_col = tcrw_pkg::COL_W'(target - int'(r.origin_col));
		end else begin
			r.origin_col = tcrw_pkg::COL_W'($urandom);
			r.cursor_col = tcrw_pkg::COL_W'($urandom);
		end
		r.char_code = tcrw_pkg::BYTE_W'($urandom);
		r.attr_byte = tcrw_pkg::BYTE_W'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: r.run_count = tcrw_pkg::COUNT_W'($urandom_range(0, 15));
			5, 6, 7:       r.run_count = tcrw_pkg::COUNT_W'($urandom_range(0, COLS));
			default:       r.run_count = tcrw_pkg::COUNT_W'($urandom);
		endcase
		return r;
	endfunction

	task automatic send_run(run_req_t r);
		int row;
		int first;
		int last;
		// Single-byte writes only on cells that already hold a full value
		row = int'(r.origin_row) + int'(r.cursor_row);
		if (row < ROWS && (r.command == tcrw_pkg::CMD_ATTR ||
				r.command == tcrw_pkg::CMD_CHAR)) begin
			first = int'(r.origin_col) + int'(r.cursor_col);
			last  = first + int'(r.run_count);
			if (last > COLS)
				last = COLS;
			for (int c = first; c < last; c++)
				if (!cell_written[row*COLS + c])
					r.command = tcrw_pkg::CMD_BOTH;
		end
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		{command, origin_row, cursor_row, origin_col, cursor_col,
			char_code, attr_byte, run_count} <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_q.push_back(predict_run(r));
	endtask

	task automatic test_row_limits();
		// rejected before anything was written: pending flag still low
		send_run(make_req(tcrw_pkg::CMD_BOTH, 25, 0, 0, 0, 8'h41, 8'h07, 4));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 24, 0, 0, 0, 8'h00, 8'h00, 3));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 0, 24, 10, 5, 8'hFF, 8'hFF, 2));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 0, 0, 0, 0, 8'h20, 8'h1F, 1));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 12, 13, 0, 0, 8'h20, 8'h1F, 1));
		send_run(make_req(CMD_SPARE, 31, 31, 127, 127, 8'hFF, 8'hFF, 127));
	endtask

	task automatic test_run_clipping();
		send_run(make_req(tcrw_pkg::CMD_BOTH, 1, 0, 79, 0, 8'h5A, 8'hA5, 1));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 2, 0, 40, 39, 8'h5A, 8'hA5, 2));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 0, 3, 0, 0, 8'h11, 8'h22, 80));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 4, 0, 0, 0, 8'h33, 8'h44, 127));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 5, 0, 80, 0, 8'h55, 8'h66, 0));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 6, 0, 0, 80, 8'h77, 8'h88, 5));
		send_run(make_req(tcrw_pkg::CMD_BOTH, 7, 0, 127, 127, 8'h99, 8'hAA, 127));
	endtask

	task automatic test_commands();
		send_run(make_req(tcrw_pkg::CMD_BOTH, 8, 0, 10, 0, 8'hC3, 8'h3C, 20));
		send_run(make_req(tcrw_pkg::CMD_ATTR, 8, 0, 12, 3, 8'h00, 8'hFF, 5));
		send_run(make_req(tcrw_pkg::CMD_CHAR, 0, 8, 5, 5, 8'hFF, 8'h00, 10));
		send_run(make_req(CMD_SPARE, 8, 0, 2, 0, 8'h81, 8'h18, 30));
	endtask

	task automatic test_empty_runs();
		send_run(make_req(tcrw_pkg::CMD_BOTH, 9, 0, 40, 0, 8'h01, 8'h02, 0));
		send_run(make_req(tcrw_pkg::CMD_CHAR, 9, 0, 0, 0, 8'h03, 8'h04, 0));
		send_run(make_req(tcrw_pkg::CMD_ATTR, 10, 0, 79, 0, 8'h05, 8'h06, 0));
	endtask

	task automatic test_random_runs(int n);
		calm = 1'b0;
		repeat (n)
			send_run(random_req());
	endtask

	task automatic test_steady_stream(int n);
		// no idling on either side for the closing stretch
		calm = 1'b1;
		repeat (n)
			send_run(random_req());
	endtask

	initial begin : result_check
		int stall;
		run_res_t want;
		stall = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result transaction: status %0d left %0d right %0d",
						status, left_dirty_out, right_dirty_out);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (want.status == tcrw_pkg::ST_REJECT)
						rejects_seen++;
					if (want.status == tcrw_pkg::ST_CLIP)
						clips_seen++;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (left_dirty_out !== want.left_mark) begin
						$error("left_dirty_out: expected %0d, got %0d",
							want.left_mark, left_dirty_out);
						fail_count++;
					end
					if (right_dirty_out !== want.right_mark) begin
						$error("right_dirty_out: expected %0d, got %0d",
							want.right_mark, right_dirty_out);
						fail_count++;
					end
					if (delta_out !== want.delta) begin
						$error("delta_out: expected %0d, got %0d", want.delta, delta_out);
						fail_count++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		fail_count = 0;
		checked = 0;
		rejects_seen = 0;
		clips_seen = 0;
		calm = 1'b0;
		screen_pending = 1'b0;
		for (int r = 0; r < ROWS; r++) begin
			row_left[r] = COLS;
			row_right[r] = 0;
		end
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		{command, origin_row, cursor_row, origin_col, cursor_col,
			char_code, attr_byte, run_count} <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_row_limits();
		test_run_clipping();
		test_commands();
		test_empty_runs();
		test_random_runs(1280);
		test_steady_stream(300);

		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d run results (%0d rejected rows, %0d clipped runs), %0d mismatches.",
			checked, rejects_seen, clips_seen, fail_count);
		if (fail_count == 0)
			$display("tb_text_cell_run_writer_unit: clean");
		else
			$display("tb_text_cell_run_writer_unit: errors");
		$finish;
	end

endmodule

// File: text_cell_run_writer_unit.f
src/tcrw_pkg.sv
src/tcrw_ram.sv
src/tcrw_ctrl.sv
src/tcrw_dp.sv
src/text_cell_run_writer_unit.sv
tb/tb_text_cell_run_writer_unit.sv
